// ===== rtl/core/mrr_pkg.sv =====
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants for the Miller-Rabin round block.
// ----------------------------------------------------------------------------
package mrr_pkg;

   // fixed field widths of the request payload
   localparam int CAND_W = 32;
   localparam int RAND_W = 32;

   // control from the sequencer to the modular multiplier
   typedef struct packed {
      logic start;
   } mul_ctl_type;

   // status from the modular multiplier back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

// ===== rtl/core/mrr_if.sv =====
// ----------------------------------------------------------------------------
// mrr_if
// Valid/ready channels for requests and responses of the Miller-Rabin round.
// ----------------------------------------------------------------------------
interface mrr_req_if;
   logic                          valid;
   logic                          ready;
   logic [mrr_pkg::CAND_W-1:0]    candidate;
   logic [mrr_pkg::RAND_W-1:0]    random_word;

   modport source (output valid, output candidate, output random_word, input ready);
   modport sink   (input valid, input candidate, input random_word, output ready);
endinterface

interface mrr_rsp_if;
   logic valid;
   logic ready;
   logic verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

// ===== rtl/core/miller_rabin_round_top.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_round_top
// One Miller-Rabin round per request: candidate and random word in, verdict out.
// ----------------------------------------------------------------------------
// Usage: a request transfer on req carries the candidate n (taken modulo
// 2^WIDTH) and a random word. One response transfer on rsp follows with the
// verdict: 0 composite, 1 probably prime for this round. The caller repeats
// rounds with fresh random words.
// Flow: n of 3 or less, or 4, goes straight to the verdict. Otherwise the
// sequencer factors n-1 and reduces the random word (one bit a cycle),
// then runs square-and-multiply with products from the shift-and-add
// multiplier; a round takes at most about 2*WIDTH products. One request
// is in work at a time; req.ready is high while the sequencer is idle.
// The verdict sits in an output register, so a new request is taken while
// the previous verdict still waits for rsp.ready; a finished round holds
// its verdict until the output register is free.
// Reset (synchronous, active high) drops any round in work and any waiting
// verdict.
// ----------------------------------------------------------------------------
module miller_rabin_round_top #(
   parameter int WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   mrr_req_if.sink   req,
   mrr_rsp_if.source rsp
);

   localparam int SW = $clog2(WIDTH);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_STRIP = 4'd1;
   localparam logic [3:0] ST_MODR  = 4'd2;
   localparam logic [3:0] ST_POW   = 4'd3;
   localparam logic [3:0] ST_PMUL  = 4'd4;
   localparam logic [3:0] ST_PSQ   = 4'd5;
   localparam logic [3:0] ST_CHK   = 4'd6;
   localparam logic [3:0] ST_SQ    = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   localparam int RCW = $clog2(mrr_pkg::RAND_W + 1);

   logic [3:0]                state_ff, state_in;
   logic [WIDTH-1:0]          n_ff, n_in;
   logic [WIDTH-1:0]          d_ff, d_in;
   logic [SW-1:0]             s_ff, s_in;
   logic [SW-1:0]             i_ff, i_in;
   logic [mrr_pkg::RAND_W-1:0] r_ff, r_in;
   logic [RCW-1:0]            rcnt_ff, rcnt_in;
   logic [WIDTH-1:0]          rem_ff, rem_in;
   logic [WIDTH-1:0]          acc_ff, acc_in;
   logic [WIDTH-1:0]          base_ff, base_in;
   logic                      pend_ff, pend_in;
   logic                      start_ff, start_in;
   logic [WIDTH-1:0]          opa_ff, opa_in;
   logic [WIDTH-1:0]          opb_ff, opb_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      verdict_ff, verdict_in;

   logic [WIDTH-1:0]          n_req;
   logic [WIDTH-1:0]          n_m1;
   logic [WIDTH:0]            rem_t;
   logic [WIDTH-1:0]          rem_m;
   logic [SW:0]               i_next;
   logic                      out_free;
   mrr_pkg::mul_ctl_type      mul_ctl;
   mrr_pkg::mul_sts_type      mul_sts;
   logic [WIDTH-1:0]          mul_res;

   assign n_req    = WIDTH'(req.candidate);
   assign n_m1     = n_ff - WIDTH'(1);
   assign rem_m    = n_ff - WIDTH'(4);
   assign rem_t    = {rem_ff, r_ff[mrr_pkg::RAND_W-1]};
   assign i_next   = {1'b0, i_ff} + (SW+1)'(1);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign mul_ctl.start = start_ff;

   mrr_mulmod #(.WIDTH(WIDTH)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .op_a    (opa_ff),
      .op_b    (opb_ff),
      .modulus (n_ff),
      .result  (mul_res),
      .sts     (mul_sts)
   );

   // round sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      i_in         = i_ff;
      r_in         = r_ff;
      rcnt_in      = rcnt_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      pend_in      = pend_ff;
      start_in     = 1'b0;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               n_in    = n_req;
               d_in    = n_req - WIDTH'(1);
               s_in    = '0;
               r_in    = req.random_word;
               rcnt_in = '0;
               rem_in  = '0;
               if (n_req <= WIDTH'(1) || n_req == WIDTH'(4)) begin
                  pend_in  = 1'b0;
                  state_in = ST_DONE;
               end else if (n_req <= WIDTH'(3)) begin
                  pend_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STRIP;
               end
            end
         end
         // factors of two out of n-1, one per cycle
         ST_STRIP: begin
            if (d_ff[0]) begin
               state_in = ST_MODR;
            end else begin
               d_in = d_ff >> 1;
               s_in = s_ff + SW'(1);
            end
         end
         // random word mod (n-4), restoring, one bit per cycle
         ST_MODR: begin
            if (rcnt_ff == RCW'(mrr_pkg::RAND_W)) begin
               acc_in   = WIDTH'(1);
               base_in  = rem_ff + WIDTH'(2);
               state_in = ST_POW;
            end else begin
               if (rem_t >= {1'b0, rem_m}) begin
                  rem_in = WIDTH'(rem_t - {1'b0, rem_m});
               end else begin
                  rem_in = WIDTH'(rem_t);
               end
               r_in    = r_ff << 1;
               rcnt_in = rcnt_ff + RCW'(1);
            end
         end
         // square-and-multiply over the exponent bits
         ST_POW: begin
            if (d_ff == '0) begin
               state_in = ST_CHK;
            end else if (d_ff[0]) begin
               start_in = 1'b1;
               opa_in   = acc_ff;
               opb_in   = base_ff;
               state_in = ST_PMUL;
            end else begin
               start_in = 1'b1;
               opa_in   = base_ff;
               opb_in   = base_ff;
               state_in = ST_PSQ;
            end
         end
         ST_PMUL: begin
            if (mul_sts.done) begin
               acc_in   = mul_res;
               start_in = 1'b1;
               opa_in   = base_ff;
               opb_in   = base_ff;
               state_in = ST_PSQ;
            end
         end
         ST_PSQ: begin
            if (mul_sts.done) begin
               base_in  = mul_res;
               d_in     = d_ff >> 1;
               state_in = ST_POW;
            end
         end
         // first test of a^d, then start the squaring chain if s is above one
         ST_CHK: begin
            i_in = SW'(1);
            if (acc_ff == WIDTH'(1) || acc_ff == n_m1) begin
               pend_in  = 1'b1;
               state_in = ST_DONE;
            end else if (SW'(1) < s_ff) begin
               start_in = 1'b1;
               opa_in   = acc_ff;
               opb_in   = acc_ff;
               state_in = ST_SQ;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_SQ: begin
            if (mul_sts.done) begin
               acc_in = mul_res;
               i_in   = SW'(i_next);
               if (mul_res == WIDTH'(1)) begin
                  pend_in  = 1'b0;
                  state_in = ST_DONE;
               end else if (mul_res == n_m1) begin
                  pend_in  = 1'b1;
                  state_in = ST_DONE;
               end else if (i_next < {1'b0, s_ff}) begin
                  start_in = 1'b1;
                  opa_in   = mul_res;
                  opb_in   = mul_res;
               end else begin
                  pend_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         // hand the verdict to the output register once it is free
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               verdict_in   = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      s_ff       <= s_in;
      i_ff       <= i_in;
      r_ff       <= r_in;
      rcnt_ff    <= rcnt_in;
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      base_ff    <= base_in;
      pend_ff    <= pend_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      verdict_ff <= verdict_in;
   end

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.verdict = verdict_ff;

endmodule

// ===== rtl/core/mrr_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrr_mulmod
// Shift-and-add modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mrr_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mrr_pkg::mul_ctl_type ctl,
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   input  logic [WIDTH-1:0]     modulus,
   output logic [WIDTH-1:0]     result,
   output mrr_pkg::mul_sts_type sts
);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // (x + y) mod m for x, y < m without overflow
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] gap;
      gap = m - y;
      if (x >= gap) begin
         add_mod = x - gap;
      end else begin
         add_mod = x + y;
      end
   endfunction

   // one multiplier bit per cycle, stop once the multiplier runs out
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = add_mod(acc_ff, a_ff, m_ff);
            end
            a_in = add_mod(a_ff, a_ff, m_ff);
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign result   = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// ===== tb/tb_mrr_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mrr_if
// Testbench copy point for the request and response channels.
// ----------------------------------------------------------------------------
// The channel interfaces live with the RTL; this file only carries the
// shared request record used by the testbench driver and predictor.
// ----------------------------------------------------------------------------
package tb_mrr_types;
   typedef struct packed {
      logic [mrr_pkg::CAND_W-1:0] candidate;
      logic [mrr_pkg::RAND_W-1:0] random_word;
   } round_req_type;
endpackage

// ===== tb/tb_miller_rabin_round_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_round_top
// Self-checking test of one Miller-Rabin round per request.
// ----------------------------------------------------------------------------
// Directed candidates (trivial cases, small primes, even values, strong
// pseudoprimes, word extremes) are followed by random candidates, mostly odd
// and many of them prime. Each verdict is predicted with exact modular
// arithmetic and compared in order. Sender and receiver idle in phases.
// ----------------------------------------------------------------------------
module tb_miller_rabin_round_top;

   localparam int WIDTH     = 32;
   localparam int WDOG_MAX  = 200000;
   localparam int N_RANDOM  = 120;

   logic clock;
   logic reset;

   mrr_req_if req ();
   mrr_rsp_if rsp ();

   miller_rabin_round_top #(.WIDTH(WIDTH)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   tb_mrr_types::round_req_type pending_reqs[$];
   logic       verdict_q[$];
   int         send_idle_pct;
   int         recv_stall_pct;
   bit         hold_send;
   int         mismatches;
   int         wdog;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // (a*b) mod m, exact at double width
   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
      logic [127:0] prod;
      prod = a * b;
      return 64'(prod % m);
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e,
                                           logic [63:0] m);
      logic [63:0] acc;
      acc  = 1;
      base = base % m;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, base, m);
         base = mul_mod(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // expected verdict of one round
   function automatic logic round_verdict(tb_mrr_types::round_req_type r);
      logic [63:0] n, d, x, a;
      int          s;
      n = 64'(r.candidate);
      s = 0;
      if (n <= 1 || n == 4) return 1'b0;
      if (n <= 3) return 1'b1;
      d = n - 1;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      a = 2 + (64'(r.random_word) % (n - 4));
      x = pow_mod(a, d, n);
      if (x == 1 || x == n - 1) return 1'b1;
      for (int i = 1; i < s; i++) begin
         x = mul_mod(x, x, n);
         if (x == 1) return 1'b0;
         if (x == n - 1) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit trial_prime(logic [31:0] v);
      if (v < 2) return 0;
      for (logic [31:0] f = 2; f * f <= v && f < 65536; f++)
         if (v % f == 0) return 0;
      return 1;
   endfunction

   task automatic queue_round(logic [31:0] cand, logic [31:0] rnd);
      tb_mrr_types::round_req_type r;
      r.candidate   = cand;
      r.random_word = rnd;
      pending_reqs.push_back(r);
   endtask

   // driver: one request transfer per accepted handshake
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) verdict_q.push_back(round_verdict({req.candidate, req.random_word}));
         if (pending_reqs.size() != 0 && !hold_send &&
             $urandom_range(99) >= send_idle_pct) begin
            tb_mrr_types::round_req_type r;
            r = pending_reqs.pop_front();
            req.valid       <= 1'b1;
            req.candidate   <= r.candidate;
            req.random_word <= r.random_word;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected verdict transfer: %0b", rsp.verdict);
            end else begin
               logic exp_v;
               exp_v = verdict_q.pop_front();
               if (exp_v !== rsp.verdict) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("verdict mismatch: expected %0b actual %0b",
                              exp_v, rsp.verdict);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         wdog <= 0;
      else
         wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("tb_miller_rabin_round_top: FAIL");
         $finish;
      end
   end

   function automatic bit all_idle();
      return pending_reqs.size() == 0 && !req.valid && verdict_q.size() == 0;
   endfunction

   initial begin
      logic [31:0] c;
      clock          = 1'b0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.candidate  = '0;
      req.random_word = '0;
      rsp.ready      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_send      = 1'b1;
      mismatches     = 0;
      wdog           = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // trivial cases, n = 5, even n, pseudoprimes and word extremes
      queue_round(0, 32'hFFFF_FFFF);
      queue_round(1, 0);
      queue_round(2, 32'h5555_5555);
      queue_round(3, 32'hAAAA_AAAA);
      queue_round(4, 7);
      queue_round(5, 32'hFFFF_FFFF);
      queue_round(5, 0);
      queue_round(6, 3);
      queue_round(7, 1);
      queue_round(9, 2);
      queue_round(100, 12345);
      queue_round(2047, 0);             // strong pseudoprime to base 2
      queue_round(341, 0);              // Fermat liar base 2, strong witness
      queue_round(561, 32'h0000_00FF);
      queue_round(32'd3215031751, 0);   // strong pseudoprime to small bases
      queue_round(32'd4294967291, 32'hFFFF_FFFF);  // largest 32-bit prime
      queue_round(32'hFFFF_FFFF, 32'h1234_5678);
      queue_round(32'hFFFF_FFFE, 32'h8765_4321);
      queue_round(32'h8000_0001, 32'hFFFF_FFFE);
      queue_round(65537, 32'h0F0F_0F0F);
      queue_round(97, 32'hF0F0_F0F0);
      hold_send = 1'b0;
      while (!all_idle()) @(posedge clock);

      // random phases with varied idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            case ($urandom_range(9))
               0: c = $urandom_range(20);
               1, 2, 3: begin
                  c = $urandom | 1;
                  if ($urandom_range(1)) c = c >> $urandom_range(28);
                  c = c | 1;
                  while (!trial_prime(c) && c < 32'hFFFF_FFF0) c = c + 2;
               end
               4: c = $urandom & ~32'h1;
               default: c = $urandom | 1;
            endcase
            queue_round(c, $urandom);
         end
         while (!all_idle()) @(posedge clock);
      end
      repeat (3000) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("tb_miller_rabin_round_top: PASS");
      else
         $display("tb_miller_rabin_round_top: FAIL");
      $finish;
   end

endmodule
